[rtl/core/hpf_pkg.sv]
// shared constants and types for the histogram peak finder
package hpf_pkg;

  localparam int MAX_BINS   = 1024;
  localparam int MAX_PEAKS  = 16;

  localparam int BIN_W      = 16;
  localparam int COUNT_W    = 11;
  localparam int INDEX_W    = 10;
  localparam int WIDTH_W    = 8;
  localparam int PEAK_SEL_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int HELD_W     = $clog2(MAX_PEAKS + 1);

  // reciprocal of the width divisor, 16 fraction bits, exact for counts up to MAX_BINS
  localparam int RECIP_FRAC_W = 16;
  localparam int RECIP_5      = 13108;
  localparam int RECIP_W      = 15;
  localparam int PROD_W       = COUNT_W + RECIP_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

  localparam logic [COUNT_W-1:0] BIN_COUNT_RESET = 11'd256;

  // one queue word: an optional peak candidate and an optional end of histogram
  typedef struct packed {
    logic                     cand;
    logic                     hist_end;
    logic [INDEX_W-1:0]       idx;
    logic signed [BIN_W-1:0]  height;
    logic [WIDTH_W-1:0]       width;
  } hpf_entry_t;

endpackage

[rtl/core/hpf_front.sv]
// front part: config registers, bin flooring, peak test and end-of-histogram detect
module hpf_front
  import hpf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [BIN_W-1:0] in_bin_value,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    q_full,
  output logic                    q_push,
  output hpf_entry_t              q_entry
);

  logic [COUNT_W-1:0]      bin_count_r, bin_count_nxt;
  logic signed [BIN_W-1:0] threshold_r, threshold_nxt;
  logic signed [BIN_W-1:0] older_r, older_nxt;
  logic signed [BIN_W-1:0] middle_r, middle_nxt;
  logic [INDEX_W-1:0]      pos_r, pos_nxt;

  logic                    accept;
  logic signed [BIN_W-1:0] floored;
  logic [COUNT_W-1:0]      count_eff;
  logic [PROD_W-1:0]       width_prod;
  logic                    is_peak;
  logic                    is_end;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    floored = (in_bin_value < threshold_r) ? threshold_r : in_bin_value;

    if (bin_count_r == '0) begin
      count_eff = COUNT_W'(1);
    end else if (bin_count_r > COUNT_W'(MAX_BINS)) begin
      count_eff = COUNT_W'(MAX_BINS);
    end else begin
      count_eff = bin_count_r;
    end

    // count / 5 by reciprocal
    width_prod = PROD_W'(count_eff) * PROD_W'(RECIP_5);

    is_peak = (pos_r >= INDEX_W'(2)) &&
              (((middle_r >= older_r) && (middle_r > floored)) ||
               ((middle_r > older_r) && (middle_r >= floored)));
    is_end  = ({1'b0, pos_r} + COUNT_W'(1)) >= count_eff;

    q_push           = accept && (is_peak || is_end);
    q_entry.cand     = is_peak;
    q_entry.hist_end = is_end;
    q_entry.idx      = pos_r - INDEX_W'(1);
    q_entry.height   = middle_r;
    q_entry.width    = width_prod[RECIP_FRAC_W +: WIDTH_W];
  end

  always_comb begin
    bin_count_nxt = bin_count_r;
    threshold_nxt = threshold_r;
    older_nxt     = older_r;
    middle_nxt    = middle_r;
    pos_nxt       = pos_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIN_COUNT: bin_count_nxt = cfg_data[COUNT_W-1:0];
        REG_THRESHOLD: threshold_nxt = $signed(cfg_data[BIN_W-1:0]);
        default: ;
      endcase
    end
    if (accept) begin
      if (is_end) begin
        pos_nxt    = '0;
        older_nxt  = '0;
        middle_nxt = '0;
      end else begin
        pos_nxt    = pos_r + INDEX_W'(1);
        older_nxt  = middle_r;
        middle_nxt = floored;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= BIN_COUNT_RESET;
      threshold_r <= '0;
      older_r     <= '0;
      middle_r    <= '0;
      pos_r       <= '0;
    end else begin
      bin_count_r <= bin_count_nxt;
      threshold_r <= threshold_nxt;
      older_r     <= older_nxt;
      middle_r    <= middle_nxt;
      pos_r       <= pos_nxt;
    end
  end

endmodule

[rtl/core/hpf_queue.sv]
// short fifo of classified words between front and back
module hpf_queue
  import hpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  hpf_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       empty,
  output hpf_entry_t head
);

  hpf_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/core/hpf_back.sv]
// back part: peak list with parallel distance checks and result emission
module hpf_back
  import hpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  hpf_entry_t         q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [INDEX_W-1:0] out_peak_index,
  output logic               out_peak_found,
  output logic               out_last_peak
);

  typedef enum logic {ST_RUN, ST_EMIT} state_t;

  state_t                  state_r, state_nxt;
  logic [INDEX_W-1:0]      ppos_r [MAX_PEAKS];
  logic signed [BIN_W-1:0] phgt_r [MAX_PEAKS];
  logic [HELD_W-1:0]       held_r, held_nxt;
  logic [PEAK_SEL_W-1:0]   emit_r, emit_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]      out_index_r, out_index_nxt;
  logic                    out_found_r, out_found_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [MAX_PEAKS-1:0]    close_v;
  logic [MAX_PEAKS-1:0]    higher_v;
  logic [INDEX_W-1:0]      gap_v [MAX_PEAKS];
  logic                    any_close;
  logic [PEAK_SEL_W-1:0]   first_sel;
  logic                    wr_en;
  logic [PEAK_SEL_W-1:0]   wr_sel;
  logic                    slot_free;
  logic                    emit_last;

  assign out_valid      = out_valid_r;
  assign out_peak_index = out_index_r;
  assign out_peak_found = out_found_r;
  assign out_last_peak  = out_last_r;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_RUN) && !q_empty;
  assign emit_last = (HELD_W'(emit_r) + HELD_W'(1)) == held_r;

  // distance against every held peak side by side
  always_comb begin
    for (int j = 0; j < MAX_PEAKS; j++) begin
      gap_v[j]    = (q_head.idx > ppos_r[j]) ? q_head.idx - ppos_r[j]
                                             : ppos_r[j] - q_head.idx;
      close_v[j]  = (HELD_W'(j) < held_r) && (gap_v[j] < INDEX_W'(q_head.width));
      higher_v[j] = q_head.height > phgt_r[j];
    end
    any_close = |close_v;
    first_sel = '0;
    for (int j = MAX_PEAKS - 1; j >= 0; j--) begin
      if (close_v[j]) begin
        first_sel = PEAK_SEL_W'(j);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r;
    out_index_nxt = out_index_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_sel        = first_sel;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_RUN: begin
        if (!q_empty) begin
          if (q_head.cand) begin
            if (any_close) begin
              wr_en  = higher_v[first_sel];
              wr_sel = first_sel;
            end else if (held_r < HELD_W'(MAX_PEAKS)) begin
              wr_en    = 1'b1;
              wr_sel   = PEAK_SEL_W'(held_r);
              held_nxt = held_r + HELD_W'(1);
            end
          end
          if (q_head.hist_end) begin
            state_nxt = ST_EMIT;
            emit_nxt  = '0;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (held_r == '0) begin
            // empty list: one not-found word
            out_index_nxt = '0;
            out_found_nxt = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_RUN;
          end else begin
            out_index_nxt = ppos_r[emit_r];
            out_found_nxt = 1'b1;
            out_last_nxt  = emit_last;
            emit_nxt      = emit_r + PEAK_SEL_W'(1);
            if (emit_last) begin
              held_nxt  = '0;
              state_nxt = ST_RUN;
            end
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ppos_r[wr_sel] <= q_head.idx;
      phgt_r[wr_sel] <= q_head.height;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      held_r      <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
      out_index_r <= '0;
      out_found_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      out_index_r <= out_index_nxt;
      out_found_r <= out_found_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

endmodule

[rtl/core/histogram_peak_finder.sv]
// top level of the histogram peak finder
//
// in_ channel: one histogram bin word per accepted cycle, bins in index order.
// cfg_ channel: register 0 is the bin count, register 1 the signed floor;
// cfg_ready is always high; the user must write only while the block is idle (unchecked).
// out_ channel: after the final bin of a histogram the block sends the held
// peak positions in list order, one word per cycle while out_stall is low,
// with out_last_peak on the last; a histogram without peaks gives one word
// with out_peak_found low. Throughput: one bin per cycle while in_stall is low.
// Bins that carry a peak candidate or end a histogram go through a four-word
// queue to the peak list, which takes one word per cycle while not emitting.
// The final bin's word passes the queue, then the list's move to emission,
// then the output register; during emission the list does not take queue
// words, so in_stall rises once the queue fills during emission.
// A stalled out_ word holds; emission waits on it.
// Reset (synchronous, rst_n low) restores bin count 256, floor 0, and clears
// the bin position, the neighbor bins, the queue and the peak list.
module histogram_peak_finder
  import hpf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [BIN_W-1:0] in_bin_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [INDEX_W-1:0]      out_peak_index,
  output logic                    out_peak_found,
  output logic                    out_last_peak
);

  logic       q_full, q_empty, q_push, q_pop;
  hpf_entry_t q_entry, q_head;

  assign cfg_ready = 1'b1;

  hpf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_bin_value (in_bin_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  hpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  hpf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_peak_index (out_peak_index),
    .out_peak_found (out_peak_found),
    .out_last_peak  (out_last_peak)
  );

  // a word is never pushed into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
    else $error("queue overflow");

  // a not-found word ends its histogram and carries index zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_peak_found) |-> (out_last_peak && out_peak_index == '0))
    else $error("bad not-found word");

  // the queue is not drained while results are being emitted
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_peak) |-> !q_pop)
    else $error("queue popped during emission");

endmodule

[dv/tb_top.sv]
// testbench for histogram_peak_finder: tracks every bin and checks each peak word
`timescale 1ns / 1ps

module tb_top
  import hpf_pkg::*;
();

  localparam int WIDTH_DIVISOR  = 5;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BINS    = 40;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic               found;
    logic               last;
  } peak_word_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [BIN_W-1:0]       in_bin_value = '0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = REG_BIN_COUNT;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [INDEX_W-1:0]            out_peak_index;
  logic                          out_peak_found;
  logic                          out_last_peak;

  // mirror of the block's registers and histogram state
  logic [COUNT_W-1:0]            cur_bin_count = BIN_COUNT_RESET;
  logic signed [BIN_W-1:0]       cur_threshold = '0;
  logic signed [BIN_W-1:0]       older_bin = '0;
  logic signed [BIN_W-1:0]       middle_bin = '0;
  int                            bin_pos = 0;
  int                            peak_pos [MAX_PEAKS];
  logic signed [BIN_W-1:0]       peak_height [MAX_PEAKS];
  int                            peaks_held = 0;

  peak_word_t                    peak_words_due [$];
  peak_word_t                    due_word;

  int                            bins_sent = 0;
  int                            words_seen = 0;
  int                            histograms_closed = 0;
  int                            mismatches = 0;
  int                            idle_cycles = 0;

  // sender pacing
  bit                            pace_on = 1'b1;
  int                            burst_left = 0;

  // receiver pattern
  logic                          hold_armed = 1'b0;
  int                            hold_count = 0;
  int                            stall_level = 0;
  int                            stall_span = 0;

  histogram_peak_finder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_bin_value   (in_bin_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_peak_index (out_peak_index),
    .out_peak_found (out_peak_found),
    .out_last_peak  (out_last_peak)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // first stored peak closer than the width decides; otherwise append if room
  function automatic void offer_peak(input int idx, input logic signed [BIN_W-1:0] height,
                                     input int width);
    int gap;
    for (int j = 0; j < peaks_held; j++) begin
      gap = (idx > peak_pos[j]) ? idx - peak_pos[j] : peak_pos[j] - idx;
      if (gap < width) begin
        if (height > peak_height[j]) begin
          peak_pos[j] = idx;
          peak_height[j] = height;
        end
        return;
      end
    end
    if (peaks_held < MAX_PEAKS) begin
      peak_pos[peaks_held] = idx;
      peak_height[peaks_held] = height;
      peaks_held++;
    end
  endfunction

  function automatic void advance_histogram(input logic signed [BIN_W-1:0] raw);
    int span;
    int width;
    int pos;
    logic signed [BIN_W-1:0] level;
    peak_word_t w;
    span = (cur_bin_count == 0) ? 1 : int'(cur_bin_count);
    if (span > MAX_BINS) span = MAX_BINS;
    width = span / WIDTH_DIVISOR;
    pos = bin_pos;
    level = (raw < cur_threshold) ? cur_threshold : raw;
    if (pos >= 2 && ((middle_bin >= older_bin && middle_bin > level) ||
                     (middle_bin > older_bin && middle_bin >= level)))
      offer_peak(pos - 1, middle_bin, width);
    older_bin = middle_bin;
    middle_bin = level;
    if (pos + 1 >= span) begin
      if (peaks_held == 0) begin
        w.idx = '0;
        w.found = 1'b0;
        w.last = 1'b1;
        peak_words_due = {peak_words_due, w};
      end else begin
        for (int j = 0; j < peaks_held; j++) begin
          w.idx = INDEX_W'(peak_pos[j]);
          w.found = 1'b1;
          w.last = (j == peaks_held - 1);
          peak_words_due = {peak_words_due, w};
        end
      end
      histograms_closed++;
      bin_pos = 0;
      peaks_held = 0;
      older_bin = '0;
      middle_bin = '0;
    end else begin
      bin_pos = pos + 1;
    end
  endfunction

  task automatic send_bin(input logic signed [BIN_W-1:0] value);
    if (pace_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_bin_value <= value;
    do @(posedge clk); while (in_stall);
    advance_histogram(value);
    bins_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // wait out every pending word, then the block's own latency
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (peak_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [COUNT_W-1:0] count,
                           input logic signed [BIN_W-1:0] floor_value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_BIN_COUNT;
    cfg_data <= CFG_DATA_W'(count);
    do @(posedge clk); while (!cfg_ready);
    cur_bin_count = count;
    cfg_index <= REG_THRESHOLD;
    cfg_data <= floor_value;
    do @(posedge clk); while (!cfg_ready);
    cur_threshold = floor_value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_field_extremes();
    configure(11'd5, -16'sd32768);
    send_bin(-16'sd32768);
    send_bin(16'sd32767);
    send_bin(-16'sd32768);
    send_bin(16'sd32767);
    send_bin(16'sd0);
    drain();
  endtask

  // plateau peak, a higher close peak replacing it, an equal one dropped
  task automatic test_plateau_and_replace();
    configure(11'd15, 16'sd0);
    send_bin(16'sd0);
    send_bin(16'sd7);
    send_bin(16'sd7);
    send_bin(16'sd9);
    send_bin(-16'sd300);
    send_bin(16'sd9);
    repeat (9) send_bin(16'sd0);
    drain();
  endtask

  task automatic test_short_histograms();
    configure(11'd0, 16'sd32767);
    send_bin(16'sd32767);
    send_bin(-16'sd1);
    configure(11'd2, 16'sd0);
    send_bin(16'sd100);
    send_bin(16'sd3);
    drain();
  endtask

  task automatic test_midstream_config();
    configure(11'd8, 16'sd0);
    send_bin(16'sd0);
    send_bin(16'sd30);
    send_bin(16'sd0);
    drain();
    configure(11'd8, 16'sd20);
    send_bin(16'sd10);
    drain();
    // shrinking the count ends the histogram on the next word
    configure(11'd3, 16'sd20);
    send_bin(16'sd0);
    drain();
  endtask

  // widen the count step by step so more than MAX_PEAKS peaks stay apart
  task automatic test_list_overflow();
    int next_peak;
    int prev_peak;
    prev_peak = -2;
    for (int k = 0; k <= MAX_PEAKS; k++) begin
      next_peak = (k == 0) ? 1 : prev_peak + 2;
      while (next_peak - prev_peak < (next_peak + 3) / WIDTH_DIVISOR) next_peak++;
      drain();
      configure(COUNT_W'(next_peak + 3), 16'sd0);
      while (bin_pos < next_peak) send_bin(-BIN_W'($urandom_range(0, 32767)));
      send_bin(BIN_W'($urandom_range(1, 32767)));
      send_bin(-BIN_W'($urandom_range(0, 32767)));
      prev_peak = next_peak;
    end
    send_bin(-BIN_W'($urandom_range(0, 32767)));
    drain();
  endtask

  // an oversized count saturates, so close peaks merge under the widest width
  task automatic test_saturated_count();
    configure(11'd2047, -16'sd32768);
    repeat (40) send_bin(BIN_W'($urandom));
    // a short count closes the long histogram on the next word
    configure(11'd3, -16'sd32768);
    send_bin(BIN_W'($urandom));
    drain();
  endtask

  // output held off while bins keep coming, so the queue fills and stalls input
  task automatic test_output_backpressure();
    configure(11'd0, 16'sd0);
    pace_on = 1'b0;
    hold_armed <= 1'b1;
    repeat (24) send_bin(BIN_W'($urandom));
    drain();
    hold_armed <= 1'b0;
    pace_on = 1'b1;
  endtask

  task automatic test_random_histograms();
    int sent;
    int pick;
    logic [COUNT_W-1:0] count;
    logic signed [BIN_W-1:0] floor_value;
    sent = 0;
    while (sent < RANDOM_BINS) begin
      drain();
      pick = $urandom_range(0, 9);
      if (pick == 0) count = COUNT_W'($urandom_range(0, 4));
      else if (pick == 9) count = COUNT_W'($urandom_range(41, 120));
      else count = COUNT_W'($urandom_range(5, 40));
      pick = $urandom_range(0, 9);
      if (pick == 0) floor_value = -16'sd32768;
      else if (pick == 1) floor_value = 16'sd32767;
      else if (pick == 2) floor_value = BIN_W'($urandom);
      else floor_value = BIN_W'($urandom_range(0, 60)) - 16'sd30;
      configure(count, floor_value);
      pace_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 30)) begin
        if ($urandom_range(0, 7) == 0) send_bin(BIN_W'($urandom));
        else send_bin(BIN_W'($urandom_range(0, 80)) - 16'sd40);
        sent++;
      end
    end
    pace_on = 1'b1;
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_count <= 0;
      stall_span <= 0;
    end else if (!hold_armed) begin
      hold_count <= 0;
      if (stall_span == 0) begin
        stall_level <= $urandom_range(0, 3);
        stall_span <= $urandom_range(16, 96);
      end else begin
        stall_span <= stall_span - 1;
      end
      out_stall <= ($urandom_range(0, 7) < stall_level * 2);
    end else if (hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(0, 7) < stall_level * 2);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (peak_words_due.size() == 0) begin
        $error("unexpected word: peak_index %0d peak_found %0b last_peak %0b",
               out_peak_index, out_peak_found, out_last_peak);
        mismatches++;
      end else begin
        due_word = peak_words_due.pop_front();
        if (out_peak_index !== due_word.idx) begin
          $error("peak_index: expected %0d, got %0d", due_word.idx, out_peak_index);
          mismatches++;
        end
        if (out_peak_found !== due_word.found) begin
          $error("peak_found: expected %0b, got %0b", due_word.found, out_peak_found);
          mismatches++;
        end
        if (out_last_peak !== due_word.last) begin
          $error("last_peak: expected %0b, got %0b", due_word.last, out_last_peak);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_plateau_and_replace();
    test_short_histograms();
    test_midstream_config();
    test_list_overflow();
    test_saturated_count();
    test_output_backpressure();
    test_random_histograms();
    drain();
    $display("tb_top: %0d bins in %0d histograms, %0d peak words compared",
             bins_sent, histograms_closed, words_seen);
    $display("tb_top: counts 0 to 2047, floors at both ends, overfull list, long output hold");
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
